### rtl/core/hnhs_pkg.sv
// ----------------------------------------------------------------------------
// hnhs_pkg
// Shared types, codes and helpers of the nearest-hash search store.
// ----------------------------------------------------------------------------
package hnhs_pkg;

    localparam int ENTRY_DEPTH_DEF   = 4096;
    localparam int SECTION_COUNT_DEF = 4;
    localparam int RESULT_DEPTH_DEF  = 64;

    localparam int HASH_W        = 64;
    localparam int ID_W          = 32;
    localparam int DIST_W        = 7;
    localparam int CNT_W         = 7;
    localparam int SECTION_BITS  = 16;
    localparam int SECTION_WAYS  = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FULL   = 2'd1;
    localparam logic [1:0] OP_FAST   = 2'd2;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_MATCH    = 2'd2;
    localparam logic [1:0] STAT_PAD      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic offer;
        logic pop;
    } t_rank_ctl;

    function automatic logic [DIST_W-1:0] f_popcount64(input logic [HASH_W-1:0] v);
        logic [3:0]        byte_cnt [8];
        logic [DIST_W-1:0] sum;
        for (int b = 0; b < 8; b++) begin
            byte_cnt[b] = 4'd0;
            for (int k = 0; k < 8; k++) begin
                byte_cnt[b] = byte_cnt[b] + {3'd0, v[8*b+k]};
            end
        end
        sum = '0;
        for (int b = 0; b < 8; b++) begin
            sum = sum + {3'd0, byte_cnt[b]};
        end
        return sum;
    endfunction

endpackage

### rtl/core/hnhs_rank.sv
// ----------------------------------------------------------------------------
// hnhs_rank
// Sorted list of the best matches; parallel insert, pops from the head.
// ----------------------------------------------------------------------------
module hnhs_rank
    import hnhs_pkg::*;
#(
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF,
    parameter int RW           = $clog2(RESULT_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rank_ctl         i_ctl,
    input  logic [RW-1:0]     i_limit,
    input  logic [ID_W-1:0]   i_id,
    input  logic [DIST_W-1:0] i_dist,
    output logic [ID_W-1:0]   o_head_id,
    output logic [DIST_W-1:0] o_head_dist,
    output logic [RW-1:0]     o_fill
);

    logic [ID_W-1:0]   r_slot_id   [RESULT_DEPTH];
    logic [DIST_W-1:0] r_slot_dist [RESULT_DEPTH];
    logic [ID_W-1:0]   n_slot_id   [RESULT_DEPTH];
    logic [DIST_W-1:0] n_slot_dist [RESULT_DEPTH];
    logic [RW-1:0]     r_fill;
    logic [RW-1:0]     n_fill;
    logic [RESULT_DEPTH-1:0] gt;
    logic              any_new;

    always_comb begin
        for (int i = 0; i < RESULT_DEPTH; i++) begin
            gt[i] = (RW'(i) >= r_fill) || (r_slot_dist[i] > i_dist);
        end
        any_new = 1'b0;
        n_fill  = r_fill;
        for (int i = 0; i < RESULT_DEPTH; i++) begin
            n_slot_id[i]   = r_slot_id[i];
            n_slot_dist[i] = r_slot_dist[i];
        end
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.offer) begin
            // sorted list: slots past the insert point move down by one
            for (int i = 0; i < RESULT_DEPTH; i++) begin
                if (RW'(i) < i_limit && gt[i]) begin
                    if (i == 0 || !gt[(i > 0) ? i-1 : 0]) begin
                        n_slot_id[i]   = i_id;
                        n_slot_dist[i] = i_dist;
                        any_new        = 1'b1;
                    end else begin
                        n_slot_id[i]   = r_slot_id[(i > 0) ? i-1 : 0];
                        n_slot_dist[i] = r_slot_dist[(i > 0) ? i-1 : 0];
                    end
                end
            end
            if (any_new && r_fill < i_limit) begin
                n_fill = r_fill + 1'b1;
            end
        end else if (i_ctl.pop) begin
            for (int i = 0; i < RESULT_DEPTH - 1; i++) begin
                n_slot_id[i]   = r_slot_id[i+1];
                n_slot_dist[i] = r_slot_dist[i+1];
            end
            if (r_fill != '0) begin
                n_fill = r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RESULT_DEPTH; i++) begin
            r_slot_id[i]   <= n_slot_id[i];
            r_slot_dist[i] <= n_slot_dist[i];
        end
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_head_id   = r_slot_id[0];
    assign o_head_dist = r_slot_dist[0];
    assign o_fill      = r_fill;

endmodule

### rtl/core/hamming_nearest_hash_search_top.sv
// ----------------------------------------------------------------------------
// hamming_nearest_hash_search_top
// Hash store with full and section-filtered Hamming nearest search.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one request: insert, full
// search or fast search. Output channel (o_out_valid / i_out_stall) gives
// result items from an output register; o_last_item marks the final one.
// An insert goes to a response state, then loads its one item into the output
// register once that register is free. A full search reads one stored entry
// per cycle from the entry memory, then drains the read / distance / rank
// pipe; the result items follow, one item per cycle while the receiver does
// not stall. A fast search runs SECTION_COUNT passes over the memory, one
// after another, since the memory has a single read port. A search request
// with a result count of zero, or an unused operation code, gives nothing.
// The block takes one request at a time; o_in_stall is high until the last
// result item of the current request has been loaded into the output
// register. When the receiver stalls, the item held there stays and the
// sequence pauses. Reset empties the store and the ranked list at once.
// ----------------------------------------------------------------------------
module hamming_nearest_hash_search_top
    import hnhs_pkg::*;
#(
    parameter int ENTRY_DEPTH   = ENTRY_DEPTH_DEF,
    parameter int SECTION_COUNT = SECTION_COUNT_DEF,
    parameter int RESULT_DEPTH  = RESULT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [HASH_W-1:0] i_hash_value,
    input  logic [DIST_W-1:0] i_max_distance,
    input  logic [CNT_W-1:0]  i_result_count,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [ID_W-1:0]   o_match_id,
    output logic [DIST_W-1:0] o_match_distance,
    output logic              o_last_item
);

    localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW = $clog2(ENTRY_DEPTH + 1);
    localparam int PW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
    localparam int RW = $clog2(RESULT_DEPTH + 1);

    logic [HASH_W-1:0] mem_hash [ENTRY_DEPTH];
    logic [ID_W-1:0]   mem_id   [ENTRY_DEPTH];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_addr, n_addr;
    logic [PW-1:0]     r_pass, n_pass;
    logic              r_fast, n_fast;
    logic [HASH_W-1:0] r_query, n_query;
    logic [DIST_W-1:0] r_maxd, n_maxd;
    logic [RW-1:0]     r_limit, n_limit;
    logic [RW-1:0]     r_left, n_left;
    logic [1:0]        r_ins_st, n_ins_st;

    logic              r_v1;
    logic [PW-1:0]     r_p1;
    logic [HASH_W-1:0] r_rd_hash;
    logic [ID_W-1:0]   r_rd_id;
    logic              r_v2;
    logic [ID_W-1:0]   r_id2;
    logic [DIST_W-1:0] r_d2;

    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic [DIST_W-1:0] r_o_dist, n_o_dist;
    logic              r_o_last, n_o_last;

    logic              accept, wr_en, out_free;
    logic [RW-1:0]     lim_in;
    logic [DIST_W-1:0] ham_dist;
    logic              qual, hit, seen;
    logic [SECTION_COUNT-1:0] sec_eq;
    t_rank_ctl         rank_ctl;
    logic [ID_W-1:0]   head_id;
    logic [DIST_W-1:0] head_dist;
    logic [RW-1:0]     fill;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign wr_en      = accept && (i_operation == OP_INSERT) && (r_count < CW'(ENTRY_DEPTH));
    assign out_free   = !r_o_valid || !i_out_stall;
    assign lim_in     = (i_result_count > CNT_W'(RESULT_DEPTH)) ?
                        RW'(RESULT_DEPTH) : i_result_count[RW-1:0];

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_hash[r_count[AW-1:0]] <= i_hash_value;
            mem_id[r_count[AW-1:0]]   <= i_entry_id;
        end
        r_rd_hash <= mem_hash[r_addr];
        r_rd_id   <= mem_id[r_addr];
    end

    // distance and pass filter: fast search takes only the first section-match pass
    always_comb begin
        ham_dist = f_popcount64(r_rd_hash ^ r_query);
        for (int j = 0; j < SECTION_COUNT; j++) begin
            sec_eq[j] = r_rd_hash[SECTION_BITS*(j % SECTION_WAYS) +: SECTION_BITS] ==
                        r_query[SECTION_BITS*(j % SECTION_WAYS) +: SECTION_BITS];
        end
        hit  = 1'b0;
        seen = 1'b0;
        for (int j = 0; j < SECTION_COUNT; j++) begin
            if (PW'(j) == r_p1) begin
                hit = sec_eq[j];
            end
            if (PW'(j) < r_p1) begin
                seen = seen | sec_eq[j];
            end
        end
        qual = !r_fast || (hit && !seen);
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= r_pass;
        r_id2 <= r_rd_id;
        r_d2  <= ham_dist;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_SCAN);
            r_v2 <= r_v1 && qual && (ham_dist < r_maxd);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pass     = r_pass;
        n_fast     = r_fast;
        n_query    = r_query;
        n_maxd     = r_maxd;
        n_limit    = r_limit;
        n_left     = r_left;
        n_ins_st   = r_ins_st;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_dist   = r_o_dist;
        n_o_last   = r_o_last;
        rank_ctl   = '0;
        rank_ctl.offer = r_v2;
        if (out_free) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_query = i_hash_value;
                    n_maxd  = i_max_distance;
                    n_limit = lim_in;
                    n_left  = lim_in;
                    n_fast  = (i_operation == OP_FAST);
                    n_addr  = '0;
                    n_pass  = '0;
                    if (i_operation == OP_INSERT) begin
                        n_ins_st = wr_en ? STAT_INSERTED : STAT_FULL;
                        if (wr_en) begin
                            n_count = r_count + 1'b1;
                        end
                        n_state = ST_RESP;
                    end else if (i_operation == OP_FULL || i_operation == OP_FAST) begin
                        rank_ctl.clear = 1'b1;
                        if (lim_in == '0) begin
                            n_state = ST_IDLE;
                        end else if (r_count == '0) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (CW'(r_addr) + 1'b1 == r_count) begin
                    n_addr = '0;
                    if (!r_fast || r_pass == PW'(SECTION_COUNT - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_EMIT;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_ins_st;
                    n_o_id     = '0;
                    n_o_dist   = '0;
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_last  = (r_left == RW'(1));
                    if (fill != '0) begin
                        n_o_status   = STAT_MATCH;
                        n_o_id       = head_id;
                        n_o_dist     = head_dist;
                        rank_ctl.pop = 1'b1;
                    end else begin
                        n_o_status = STAT_PAD;
                        n_o_id     = '0;
                        n_o_dist   = '0;
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == RW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pass     <= n_pass;
        r_fast     <= n_fast;
        r_query    <= n_query;
        r_maxd     <= n_maxd;
        r_limit    <= n_limit;
        r_left     <= n_left;
        r_ins_st   <= n_ins_st;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_dist   <= n_o_dist;
        r_o_last   <= n_o_last;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    hnhs_rank #(
        .RESULT_DEPTH (RESULT_DEPTH),
        .RW           (RW)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rank_ctl),
        .i_limit     (r_limit),
        .i_id        (r_id2),
        .i_dist      (r_d2),
        .o_head_id   (head_id),
        .o_head_dist (head_dist),
        .o_fill      (fill)
    );

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_match_id       = r_o_id;
    assign o_match_distance = r_o_dist;
    assign o_last_item      = r_o_last;

endmodule
